/* src/rdl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdl_pkg
// Shared types and constants for the reversible deque list engine: the
// channel payloads, the operation codes passed from the parser to the
// executor, and the character codes of the list syntax.
// ----------------------------------------------------------------------------
package rdl_pkg;

  // Store geometry; the depth is a power of two so ring pointers wrap freely.
  localparam int ADDR_BITS  = 10;
  localparam int DEPTH      = 1 << ADDR_BITS;
  localparam int CNT_BITS   = ADDR_BITS + 1;
  localparam int VALUE_BITS = 16;
  localparam int ACC_BITS   = VALUE_BITS + 4;

  // Operation queue between the parser and the executor.
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = 2;
  localparam int QCNT_BITS = QPTR_BITS + 1;

  // Input item kinds.
  localparam logic [1:0] KIND_TEXT    = 2'd0;
  localparam logic [1:0] KIND_COMMAND = 2'd1;
  localparam logic [1:0] KIND_DRAIN   = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_ELEMENT  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_ERROR    = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

  // Characters of the list text and the command set.
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_REV    = 8'h52;
  localparam logic [7:0] CH_DEL    = 8'h44;
  localparam int         RADIX     = 10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] element;
    logic [1:0]  status;
    logic        last_one;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_REV,
    OP_DEL,
    OP_DRAIN,
    OP_CLEAR
  } op_t;

  // One queued operation: an optional push of a parsed number, then the op.
  typedef struct packed {
    logic                  has_push;
    logic [VALUE_BITS-1:0] value;
    op_t                   op;
  } op_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_OP,
    BK_READ
  } back_state_t;

endpackage

/* src/rdl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdl_front
// Input parser. Accepts one item per cycle while the queue has room,
// accumulates decimal digits with saturation, and turns separators,
// commands, drains and clears into entries of the operation queue.
// ----------------------------------------------------------------------------
module rdl_front
  import rdl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_item_t  item,
  input  logic      q_full,
  output logic      q_write,
  output op_entry_t q_entry
);

  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  logic                  digit_seen;
  logic                  digit_seen_next;
  logic                  accept;
  logic                  is_digit;
  logic [ACC_BITS-1:0]   product;
  logic [3:0]            digit_byte;

  assign accept     = push && !q_full;
  assign is_digit   = (item.byte_in >= CH_ZERO) && (item.byte_in <= CH_NINE);
  assign digit_byte = 4'(item.byte_in - CH_ZERO);

  // Next accumulator value for a digit, before saturation.
  assign product = ACC_BITS'(acc) * ACC_BITS'(RADIX) + ACC_BITS'(digit_byte);

  // Classify the item and build the queue entry.
  always_comb begin
    acc_next         = acc;
    digit_seen_next  = digit_seen;
    q_write          = 1'b0;
    q_entry.has_push = digit_seen;
    q_entry.value    = acc;
    q_entry.op       = OP_NONE;
    if (accept) begin
      unique case (item.kind)
        KIND_TEXT: begin
          if (item.byte_in == CH_RBRACK) begin
            q_write         = digit_seen;
            acc_next        = '0;
            digit_seen_next = 1'b0;
          end else if (item.byte_in == CH_COMMA) begin
            q_write          = 1'b1;
            q_entry.has_push = 1'b1;
            acc_next         = '0;
            digit_seen_next  = 1'b0;
          end else if (is_digit) begin
            if (product > ACC_BITS'({VALUE_BITS{1'b1}})) begin
              acc_next = {VALUE_BITS{1'b1}};
            end else begin
              acc_next = product[VALUE_BITS-1:0];
            end
            digit_seen_next = 1'b1;
          end
        end
        KIND_COMMAND: begin
          q_write = 1'b1;
          if (item.byte_in == CH_REV) begin
            q_entry.op = OP_REV;
          end else if (item.byte_in == CH_DEL) begin
            q_entry.op = OP_DEL;
          end
          acc_next        = '0;
          digit_seen_next = 1'b0;
        end
        KIND_DRAIN: begin
          q_write         = 1'b1;
          q_entry.op      = OP_DRAIN;
          acc_next        = '0;
          digit_seen_next = 1'b0;
        end
        default: begin
          // Clear drops any pending number.
          q_write          = 1'b1;
          q_entry.has_push = 1'b0;
          q_entry.op       = OP_CLEAR;
          acc_next         = '0;
          digit_seen_next  = 1'b0;
        end
      endcase
    end
  end

  // Accumulator registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      digit_seen <= 1'b0;
    end else begin
      acc        <= acc_next;
      digit_seen <= digit_seen_next;
    end
  end

endmodule

/* src/rdl_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdl_fifo
// Short operation queue that decouples the parser from the executor. The
// oldest entry is shown on the read side while empty is low.
// ----------------------------------------------------------------------------
module rdl_fifo
  import rdl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  op_entry_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output op_entry_t rd_data,
  output logic      empty
);

  op_entry_t            entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_wr;
  logic                 do_rd;

  assign full    = (count == QCNT_BITS'(QDEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/rdl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdl_back
// Deque executor. Holds the ring-buffer element store and its pointers,
// carries out queued pushes, reversals, deletions, drains and clears, and
// keeps one result register for the output channel.
// ----------------------------------------------------------------------------
module rdl_back
  import rdl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  op_entry_t q_data,
  output logic      q_read,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data;

  back_state_t           state;
  back_state_t           state_next;
  logic [ADDR_BITS-1:0]  head;
  logic [ADDR_BITS-1:0]  head_next;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;
  logic                  reversed;
  logic                  reversed_next;
  logic                  error;
  logic                  error_next;
  logic                  overflow;
  logic                  overflow_next;
  logic                  pend_last;
  logic                  pend_last_next;
  logic                  out_valid;
  logic                  out_valid_next;
  out_item_t             out_reg;
  out_item_t             out_reg_next;

  logic                  wr_en;
  logic                  rd_en;
  logic                  out_free;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [ADDR_BITS-1:0]  rd_addr;

  assign empty    = !out_valid;
  assign result   = out_reg;
  assign out_free = !out_valid || pop;

  // Back of the ring for pushes; current front for pops.
  assign wr_addr = head + count[ADDR_BITS-1:0];
  assign rd_addr = reversed ? (head + count[ADDR_BITS-1:0] - 1'b1) : head;

  // Element store.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_data.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Executor sequencing: push step, op step, read step for element drains.
  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    reversed_next  = reversed;
    error_next     = error;
    overflow_next  = overflow;
    pend_last_next = pend_last;
    out_reg_next   = out_reg;
    out_valid_next = out_valid && !pop;
    q_read         = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_data.has_push) begin
            if (count == CNT_BITS'(DEPTH)) begin
              overflow_next = 1'b1;
            end else begin
              wr_en      = 1'b1;
              count_next = count + 1'b1;
            end
          end
          state_next = BK_OP;
        end
      end
      BK_OP: begin
        unique case (q_data.op)
          OP_REV: begin
            if (!error) begin
              reversed_next = !reversed;
            end
            q_read     = 1'b1;
            state_next = BK_IDLE;
          end
          OP_DEL: begin
            if (!error) begin
              if (count == '0) begin
                error_next = 1'b1;
              end else begin
                count_next = count - 1'b1;
                if (!reversed) begin
                  head_next = head + 1'b1;
                end
              end
            end
            q_read     = 1'b1;
            state_next = BK_IDLE;
          end
          OP_DRAIN: begin
            if (out_free) begin
              q_read                = 1'b1;
              state_next            = BK_IDLE;
              out_reg_next.element  = '0;
              out_reg_next.last_one = 1'b0;
              if (error) begin
                out_reg_next.status = STATUS_ERROR;
                out_valid_next      = 1'b1;
              end else if (overflow) begin
                out_reg_next.status = STATUS_OVERFLOW;
                out_valid_next      = 1'b1;
              end else if (count == '0) begin
                out_reg_next.status = STATUS_EMPTY;
                out_valid_next      = 1'b1;
              end else begin
                rd_en          = 1'b1;
                pend_last_next = (count == CNT_BITS'(1));
                count_next     = count - 1'b1;
                if (!reversed) begin
                  head_next = head + 1'b1;
                end
                state_next = BK_READ;
              end
            end
          end
          OP_CLEAR: begin
            head_next     = '0;
            count_next    = '0;
            reversed_next = 1'b0;
            error_next    = 1'b0;
            overflow_next = 1'b0;
            q_read        = 1'b1;
            state_next    = BK_IDLE;
          end
          default: begin
            // Entry only carried a push.
            q_read     = 1'b1;
            state_next = BK_IDLE;
          end
        endcase
      end
      BK_READ: begin
        out_reg_next.element  = rd_data;
        out_reg_next.status   = STATUS_ELEMENT;
        out_reg_next.last_one = pend_last;
        out_valid_next        = 1'b1;
        state_next            = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      head      <= '0;
      count     <= '0;
      reversed  <= 1'b0;
      error     <= 1'b0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      reversed  <= reversed_next;
      error     <= error_next;
      overflow  <= overflow_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_last <= pend_last_next;
    out_reg   <= out_reg_next;
  end

endmodule

/* src/reversible_deque_list_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reversible_deque_list_engine_unit
// Parses a bracketed decimal list into a 1024-entry ring-buffer deque and
// executes reverse, delete and drain requests on it.
//
// Input channel: an item is transferred when push is high and full is low.
// Text bytes build numbers; command, drain and clear items become operations
// in a four-entry queue. Result channel: the result is on result while empty
// is low and is transferred when pop is high. Only drain items give results.
//
// Timing: the parser takes one item per cycle while the queue has room. The
// executor handles each queued operation in a push step and an op step, and
// a drain that returns an element adds a read step for the registered store
// read; it finishes one operation before it takes the next. Plain digits
// stay in the parser, so the executor sets the pace only for separators,
// commands and drains.
//
// Reset clears the pointers, flags, parser and queue; the store contents are
// not cleared. A stalled receiver holds the result register, and drains wait
// in the queue; once it fills, full rises and input stalls.
// ----------------------------------------------------------------------------
module reversible_deque_list_engine_unit
  import rdl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic      q_write;
  op_entry_t q_entry;
  logic      q_full;
  logic      q_read;
  op_entry_t q_data;
  logic      q_empty;

  assign full = q_full;

  // Parser.
  rdl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .q_full  (q_full),
    .q_write (q_write),
    .q_entry (q_entry)
  );

  // Operation queue.
  rdl_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_write),
    .wr_data (q_entry),
    .full    (q_full),
    .rd_en   (q_read),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // Executor.
  rdl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_read  (q_read),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

/* src/rdl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdl_checker
// Port-level checks for the deque engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rdl_checker
  import rdl_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  // Reset leaves no result waiting and the input open.
  assert property (@(posedge clk) rst |=> empty && !full)
    else $error("engine not idle after reset");

  // Status results carry no element and no last mark.
  assert property (@(posedge clk) disable iff (rst)
      (!empty && result.status != STATUS_ELEMENT) |->
      (result.element == '0 && !result.last_one))
    else $error("status result carries element data");

  // A waiting result stays until its transfer.
  assert property (@(posedge clk) disable iff (rst) (!empty && !pop) |=> !empty)
    else $error("result withdrawn before transfer");

  // A waiting result holds its value.
  assert property (@(posedge clk) disable iff (rst) (!empty && !pop) |=> $stable(result))
    else $error("result changed while stalled");

endmodule

bind reversible_deque_list_engine_unit rdl_checker u_rdl_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
